// ===== src/wbps_pkg.sv =====
package wbps_pkg;

	localparam int MAX_PATTERN_BYTES = 32;
	localparam int OFFSET_BITS       = 32;

	localparam int PAT_WORDS    = 4;
	localparam int PAT_WORD_W   = 64;
	localparam int CARE_W       = 32;
	localparam int PAT_LEN_W    = 6;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 64;
	localparam int MATCH_OFF_W  = 32;
	localparam int LEN_BITS     = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int IDX_BITS     = $clog2(MAX_PATTERN_BYTES);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PAT_LOW    = 3'd0,
		REG_PAT_SECOND = 3'd1,
		REG_PAT_THIRD  = 3'd2,
		REG_PAT_HIGH   = 3'd3,
		REG_CARE_MASK  = 3'd4,
		REG_PAT_LENGTH = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic       update;
		logic       clear;
		logic [7:0] data_byte;
	} cell_ctrl_t;

endpackage

// ===== src/wbps_in_if.sv =====
interface wbps_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_in_range;

	modport source (output valid, output data_byte, output last_in_range, input ready);
	modport sink (input valid, input data_byte, input last_in_range, output ready);
endinterface

// ===== src/wbps_out_if.sv =====
interface wbps_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [31:0] match_offset;

	modport source (output valid, output found, output match_offset, input ready);
	modport sink (input valid, input found, input match_offset, output ready);
endinterface

// ===== src/wildcard_byte_pattern_search.sv =====
// A result is registered in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle, set by the row of shift-and match cells, while
// no result waits; the output register is refilled in the cycle it is drained.
// Reset (arst_n low, asynchronous): match state, position and output valid clear;
// pattern bytes reset to zero, care mask and pattern length to one.
module wildcard_byte_pattern_search (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	wbps_in_if.sink                        in_ch,
	wbps_out_if.source                     out_ch
);
	import wbps_pkg::*;

	logic [PAT_WORD_W-1:0]   pat_word_q [PAT_WORDS];
	logic [CARE_W-1:0]       care_q;
	logic [PAT_LEN_W-1:0]    len_q;
	logic [OFFSET_BITS-1:0]  pos_q;
	logic                    reported_q;
	logic                    res_valid_q;
	logic                    found_q;
	logic [MATCH_OFF_W-1:0]  offset_q;

	logic                    in_accept;
	logic [31:0]             len_wide;
	logic [LEN_BITS-1:0]     len_eff;
	logic [IDX_BITS-1:0]     tail_idx;
	logic [MAX_PATTERN_BYTES-1:0] hit_vec;
	logic [MAX_PATTERN_BYTES-1:0] d_vec;
	logic                    tail_hit;
	logic                    emit;
	logic [OFFSET_BITS-1:0]  start_pos;
	cell_ctrl_t              ctrl;

	assign in_accept = in_ch.valid & in_ch.ready;
	assign in_ch.ready = ~res_valid_q | out_ch.ready;

	always_comb begin
		len_wide = 32'(len_q);
		if (len_wide == 32'd0) begin
			len_wide = 32'd1;
		end else if (len_wide > 32'(MAX_PATTERN_BYTES)) begin
			len_wide = 32'(MAX_PATTERN_BYTES);
		end
		len_eff  = LEN_BITS'(len_wide);
		tail_idx = IDX_BITS'(len_wide - 32'd1);
	end

	assign ctrl.update    = in_accept & ~reported_q;
	assign ctrl.clear     = in_accept & in_ch.last_in_range;
	assign ctrl.data_byte = in_ch.data_byte;

	for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
		logic [7:0] pat_byte;
		logic       care;
		logic       enable;
		logic       prev;

		if (i < PAT_WORDS * 8) begin : g_lit
			assign pat_byte = pat_word_q[i / 8][(i % 8) * 8 +: 8];
			if (i == 0) begin : g_first
				assign care = 1'b1;
			end else begin : g_rest
				assign care = care_q[i];
			end
		end else begin : g_wild
			assign pat_byte = 8'd0;
			assign care     = 1'b0;
		end

		if (i == 0) begin : g_head
			assign prev = 1'b1;
		end else begin : g_link
			assign prev = hit_vec[i-1];
		end

		assign enable = (LEN_BITS'(i) < len_eff);

		wbps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.pat_byte (pat_byte),
			.care     (care),
			.enable   (enable),
			.prev     (prev),
			.hit_q    (hit_vec[i]),
			.d        (d_vec[i])
		);
	end

	assign tail_hit  = d_vec[tail_idx];
	assign start_pos = pos_q - OFFSET_BITS'(len_wide - 32'd1);
	assign emit      = ~reported_q & (tail_hit | in_ch.last_in_range);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_word_q[0] <= '0;
			pat_word_q[1] <= '0;
			pat_word_q[2] <= '0;
			pat_word_q[3] <= '0;
			care_q        <= CARE_W'(1);
			len_q         <= PAT_LEN_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PAT_LOW:    pat_word_q[0] <= cfg_wdata;
				REG_PAT_SECOND: pat_word_q[1] <= cfg_wdata;
				REG_PAT_THIRD:  pat_word_q[2] <= cfg_wdata;
				REG_PAT_HIGH:   pat_word_q[3] <= cfg_wdata;
				REG_CARE_MASK:  care_q        <= cfg_wdata[CARE_W-1:0];
				REG_PAT_LENGTH: len_q         <= cfg_wdata[PAT_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			reported_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				if (in_ch.last_in_range) begin
					pos_q      <= '0;
					reported_q <= 1'b0;
				end else begin
					pos_q      <= pos_q + OFFSET_BITS'(1);
					reported_q <= reported_q | tail_hit;
				end
				res_valid_q <= emit;
			end else if (out_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// hold the beat until taken
	always_ff @(posedge clk) begin
		if (in_accept && emit) begin
			found_q  <= tail_hit;
			offset_q <= tail_hit ? MATCH_OFF_W'(start_pos) : '0;
		end
	end

	assign out_ch.valid        = res_valid_q;
	assign out_ch.found        = found_q;
	assign out_ch.match_offset = offset_q;
endmodule

// ===== src/wbps_cell.sv =====
module wbps_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  wbps_pkg::cell_ctrl_t ctrl,
	input  logic [7:0]          pat_byte,
	input  logic                care,
	input  logic                enable,
	input  logic                prev,
	output logic                hit_q,
	output logic                d
);
	import wbps_pkg::*;

	assign d = prev & enable & (~care | (pat_byte == ctrl.data_byte));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.clear) begin
			hit_q <= 1'b0;
		end else if (ctrl.update) begin
			hit_q <= d;
		end
	end
endmodule

// ===== src/wbps_checker.sv =====
module wbps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        found,
	input logic [31:0] match_offset
);
	import wbps_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(match_offset))
		else $error("result beat changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_offset == 32'd0)
		else $error("not-found beat with nonzero offset");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result beat without an accepted input beat");
endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.found        (out_ch.found),
	.match_offset (out_ch.match_offset)
);

// ===== sim/testbench.sv =====
module testbench;
	import wbps_pkg::*;

	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int RANDOM_PHASES    = 8;
	localparam int BEATS_PER_PHASE  = 194;
	localparam int PRESSURE_BEATS   = 40;
	localparam int SETTLE_CYCLES    = 4;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = '1;

	typedef enum {ROW_BEAT, ROW_WRITE} row_kind_t;
	typedef enum {EXP_PREDICT, EXP_NONE, EXP_FOUND, EXP_MISSED} beat_expect_t;

	typedef struct packed {
		logic        found;
		logic [31:0] offset;
	} scan_result_t;

	typedef struct {
		row_kind_t               kind;
		logic [CFG_INDEX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0]   reg_value;
		logic [7:0]              data;
		logic                    last;
		beat_expect_t            expect_kind;
		logic [31:0]             offset;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	wbps_in_if  scan_in();
	wbps_out_if scan_out();

	wildcard_byte_pattern_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (scan_in),
		.out_ch    (scan_out)
	);

	// scanner model: configuration and per-range match state
	logic [PAT_WORD_W-1:0] pat_word [PAT_WORDS];
	logic [CARE_W-1:0]     care_bits;
	logic [PAT_LEN_W-1:0]  pat_len_reg;
	logic [31:0]           match_prefixes;
	logic [31:0]           range_pos;
	bit                    range_hit;

	scan_result_t pending_results[$];
	stim_row_t    directed_rows[$];

	beat_expect_t beat_expect;
	logic [31:0]  beat_offset;

	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_request = 1'b0;
	bit  hold_on = 1'b0;
	int  error_count;
	int  idle_count;
	int  random_beats;
	int  bytes_scanned;
	int  ranges_scanned;
	int  checked_found;
	int  checked_missed;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pattern_span();
		if (pat_len_reg == 0)
			return 1;
		if (pat_len_reg > MAX_PATTERN_BYTES)
			return MAX_PATTERN_BYTES;
		return int'(pat_len_reg);
	endfunction

	function automatic logic [7:0] pattern_byte(int i);
		return pat_word[i / 8][8 * (i % 8) +: 8];
	endfunction

	function automatic bit is_literal(int i);
		return (i == 0) || care_bits[i];
	endfunction

	function automatic void reset_model();
		foreach (pat_word[i])
			pat_word[i] = '0;
		care_bits      = CARE_W'(1);
		pat_len_reg    = PAT_LEN_W'(1);
		match_prefixes = '0;
		range_pos      = '0;
		range_hit      = 1'b0;
	endfunction

	function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_PAT_LOW:    pat_word[0] = val;
			REG_PAT_SECOND: pat_word[1] = val;
			REG_PAT_THIRD:  pat_word[2] = val;
			REG_PAT_HIGH:   pat_word[3] = val;
			REG_CARE_MASK:  care_bits   = val[CARE_W-1:0];
			REG_PAT_LENGTH: pat_len_reg = val[PAT_LEN_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void scan_byte(input logic [7:0] b, input logic last,
			output bit emits, output scan_result_t res);
		int          span;
		logic [31:0] accepts;
		logic [31:0] span_mask;
		logic [31:0] next_prefixes;
		emits = 1'b0;
		res   = '0;
		if (!range_hit) begin
			span    = pattern_span();
			accepts = '0;
			for (int i = 0; i < span; i++)
				if (!is_literal(i) || pattern_byte(i) == b)
					accepts[i] = 1'b1;
			span_mask      = (span == 32) ? '1 : ((32'd1 << span) - 32'd1);
			next_prefixes  = ((match_prefixes << 1) | 32'd1) & accepts & span_mask;
			match_prefixes = next_prefixes;
			if (next_prefixes[span-1]) begin
				emits      = 1'b1;
				res.found  = 1'b1;
				res.offset = range_pos - 32'(span - 1);
				range_hit  = 1'b1;
			end else if (last) begin
				emits = 1'b1;
			end
		end
		if (last) begin
			match_prefixes = '0;
			range_pos      = '0;
			range_hit      = 1'b0;
		end else begin
			range_pos = range_pos + 32'd1;
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		error_count++;
	endtask

	always @(posedge clk) begin : scoreboard
		bit           emits;
		bit           moved;
		scan_result_t predicted;
		scan_result_t wanted;
		moved = 1'b0;
		if (arst_n) begin
			if (scan_in.valid && scan_in.ready) begin
				moved = 1'b1;
				bytes_scanned++;
				if (scan_in.last_in_range)
					ranges_scanned++;
				scan_byte(scan_in.data_byte, scan_in.last_in_range, emits, predicted);
				case (beat_expect)
					EXP_PREDICT: if (emits) pending_results.push_back(predicted);
					EXP_FOUND:   pending_results.push_back('{found: 1'b1, offset: beat_offset});
					EXP_MISSED:  pending_results.push_back('0);
					default: ;
				endcase
			end
			if (scan_out.valid && scan_out.ready) begin
				moved = 1'b1;
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result found=%0b offset=%0d",
						scan_out.found, scan_out.match_offset));
				end else begin
					wanted = pending_results.pop_front();
					if (scan_out.found !== wanted.found)
						report_mismatch($sformatf("found: got %0b, want %0b",
							scan_out.found, wanted.found));
					if (scan_out.match_offset !== wanted.offset)
						report_mismatch($sformatf("match_offset: got %0d, want %0d",
							scan_out.match_offset, wanted.offset));
					if (wanted.found)
						checked_found++;
					else
						checked_missed++;
				end
			end
			idle_count = moved ? 0 : idle_count + 1;
			if (idle_count >= WATCHDOG_LIMIT) begin
				$display("Timeout: no beat moved for %0d cycles, %0d results outstanding",
					WATCHDOG_LIMIT, pending_results.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	always @(negedge clk)
		scan_out.ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);

	initial begin : long_hold
		forever begin
			wait (hold_request);
			hold_on <= 1'b1;
			repeat (LONG_HOLD_CYCLES) @(negedge clk);
			hold_on <= 1'b0;
			wait (!hold_request);
		end
	end

	task automatic send_beat(input logic [7:0] b, input logic last,
			input beat_expect_t ex, input logic [31:0] off);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			scan_in.valid <= 1'b0;
			@(negedge clk);
		end
		scan_in.valid         <= 1'b1;
		scan_in.data_byte     <= b;
		scan_in.last_in_range <= last;
		beat_expect           <= ex;
		beat_offset           <= off;
		do @(posedge clk); while (!scan_in.ready);
	endtask

	task automatic settle();
		@(negedge clk);
		scan_in.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		apply_reg(idx, val);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic void add_beat(logic [7:0] d, logic last, beat_expect_t ex,
			logic [31:0] off = 0);
		stim_row_t r;
		r             = '{default: '0, kind: ROW_BEAT, expect_kind: ex};
		r.data        = d;
		r.last        = last;
		r.offset      = off;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		stim_row_t r;
		r           = '{default: '0, kind: ROW_WRITE, expect_kind: EXP_NONE};
		r.reg_index = idx;
		r.reg_value = val;
		directed_rows.push_back(r);
	endfunction

	task automatic load_directed();
		// reset pattern: one literal zero byte
		add_beat(8'h00, 1'b0, EXP_FOUND, 0);
		add_beat(8'h00, 1'b1, EXP_NONE);
		add_beat(8'hFF, 1'b1, EXP_MISSED);
		add_beat(8'h00, 1'b1, EXP_FOUND, 0);
		// AB ?? CD, care bit 0 left clear
		add_write(REG_PAT_LOW, 64'h0000_0000_00CD_00AB);
		add_write(REG_CARE_MASK, 64'h4);
		add_write(REG_PAT_LENGTH, 64'd3);
		add_beat(8'hAB, 1'b0, EXP_PREDICT);
		add_beat(8'h12, 1'b0, EXP_PREDICT);
		add_beat(8'hCD, 1'b0, EXP_FOUND, 0);
		add_beat(8'h55, 1'b1, EXP_NONE);
		// restart one byte after a broken partial match
		add_beat(8'hAB, 1'b0, EXP_PREDICT);
		add_beat(8'hCD, 1'b0, EXP_PREDICT);
		add_beat(8'hAB, 1'b0, EXP_PREDICT);
		add_beat(8'h77, 1'b0, EXP_PREDICT);
		add_beat(8'hCD, 1'b1, EXP_FOUND, 2);
		add_beat(8'h00, 1'b0, EXP_PREDICT);
		add_beat(8'h00, 1'b0, EXP_PREDICT);
		add_beat(8'hCD, 1'b1, EXP_MISSED);
		// AB ??: trailing wildcard must fit in the range
		add_write(REG_PAT_LENGTH, 64'd2);
		add_write(REG_CARE_MASK, 64'h1);
		add_beat(8'h11, 1'b0, EXP_PREDICT);
		add_beat(8'hAB, 1'b1, EXP_MISSED);
		add_beat(8'hAB, 1'b0, EXP_PREDICT);
		add_beat(8'h00, 1'b1, EXP_FOUND, 0);
		add_write(REG_CARE_MASK, 64'hFFFF_FFFF);
		add_write(REG_UNUSED, '1);
		add_write(REG_PAT_LENGTH, 64'd0);
		add_beat(8'hAB, 1'b1, EXP_FOUND, 0);
		add_beat(8'hAC, 1'b1, EXP_MISSED);
	endtask

	task automatic set_idle_mode(input int mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
			default: begin send_idle_pct = 6; recv_stall_pct = 6; end
		endcase
	endtask

	task automatic configure_phase(input int phase);
		logic [CFG_DATA_W-1:0] words [PAT_WORDS];
		logic [CFG_DATA_W-1:0] care;
		logic [CFG_DATA_W-1:0] len;
		foreach (words[i])
			words[i] = {$urandom(), $urandom()};
		care = {32'd0, $urandom()};
		len  = ($urandom_range(4) != 0) ? 64'($urandom_range(1, 6))
			: 64'($urandom_range(0, 63));
		case (phase)
			0: begin care = 64'hFFFF_FFFF; len = 64'd32; end
			1: begin
				foreach (words[i])
					words[i] = '1;
				care = '0;
				len  = 64'd63;
			end
			2: begin
				foreach (words[i])
					words[i] = '0;
				care = 64'hFFFF_FFFF;
				len  = 64'd4;
			end
			default: ;
		endcase
		write_reg(REG_PAT_LOW, words[0]);
		write_reg(REG_PAT_SECOND, words[1]);
		write_reg(REG_PAT_THIRD, words[2]);
		write_reg(REG_PAT_HIGH, words[3]);
		write_reg(REG_CARE_MASK, care);
		write_reg(REG_PAT_LENGTH, len);
	endtask

	function automatic logic [7:0] noise_byte(int span);
		if ($urandom_range(1))
			return pattern_byte($urandom_range(span - 1));
		return 8'($urandom_range(255));
	endfunction

	task automatic send_random_range();
		logic [7:0] range_data[$];
		int         span;
		int         kind;
		int         cut;
		int         flip_at;
		span = pattern_span();
		kind = $urandom_range(9);
		if (kind < 2) begin
			repeat ($urandom_range(1, 2 * span + 8))
				range_data.push_back(noise_byte(span));
		end else begin
			repeat ($urandom_range(0, 6))
				range_data.push_back(noise_byte(span));
			cut     = (kind == 2) ? $urandom_range(1, span) : span;
			flip_at = $urandom_range(span - 1);
			if (!is_literal(flip_at))
				flip_at = 0;
			for (int i = 0; i < cut; i++) begin
				if (!is_literal(i))
					range_data.push_back(8'($urandom_range(255)));
				else if (kind == 3 && i == flip_at)
					range_data.push_back(pattern_byte(i) ^ 8'($urandom_range(1, 255)));
				else
					range_data.push_back(pattern_byte(i));
			end
			if (kind != 2)
				repeat ($urandom_range(0, 6))
					range_data.push_back(noise_byte(span));
		end
		foreach (range_data[i]) begin
			send_beat(range_data[i], i == range_data.size() - 1, EXP_PREDICT, 0);
			random_beats++;
		end
	endtask

	initial begin
		arst_n                = 1'b0;
		cfg_wr_en             = 1'b0;
		cfg_index             = '0;
		cfg_wdata             = '0;
		scan_in.valid         = 1'b0;
		scan_in.data_byte     = '0;
		scan_in.last_in_range = 1'b0;
		scan_out.ready        = 1'b0;
		beat_expect           = EXP_NONE;
		beat_offset           = '0;
		error_count           = 0;
		idle_count            = 0;
		random_beats          = 0;
		bytes_scanned         = 0;
		ranges_scanned        = 0;
		checked_found         = 0;
		checked_missed        = 0;
		reset_model();
		set_idle_mode(0);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		load_directed();
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				settle();
				write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
			end else begin
				send_beat(directed_rows[i].data, directed_rows[i].last,
					directed_rows[i].expect_kind, directed_rows[i].offset);
			end
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle();
			set_idle_mode(phase % 4);
			configure_phase(phase);
			if (phase == 4) begin
				// stall the result side long enough to back up the input
				hold_request = 1'b1;
				repeat (PRESSURE_BEATS) begin
					send_beat(noise_byte(pattern_span()), 1'b1, EXP_PREDICT, 0);
					random_beats++;
				end
				hold_request = 1'b0;
			end
			while (random_beats < (phase + 1) * BEATS_PER_PHASE)
				send_random_range();
		end
		settle();
		repeat (8) @(posedge clk);

		$display("Scanned %0d bytes in %0d ranges over %0d pattern setups",
			bytes_scanned, ranges_scanned, RANDOM_PHASES + 4);
		$display("Checked %0d matches and %0d misses, %0d mismatches",
			checked_found, checked_missed, error_count);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
src/wbps_pkg.sv
src/wbps_in_if.sv
src/wbps_out_if.sv
src/wbps_cell.sv
src/wildcard_byte_pattern_search.sv
src/wbps_checker.sv
sim/testbench.sv
